FILE: rtl/core/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants of the second-chance frame table.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int FRAME_SLOTS_DEF = 64;
    localparam int PAGE_W          = 20;
    localparam int COUNT_W         = 7;
    localparam logic [PAGE_W-1:0] KERNEL_BASE_RST = 20'd786432;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_TOUCH  = 3'd2,
        OP_PIN    = 3'd3,
        OP_EVICT  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_KERNEL    = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NO_VICTIM = 3'd3,
        ST_DUPLICATE = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]        status;
        logic              victim_valid;
        logic [PAGE_W-1:0] victim_page;
        logic [COUNT_W-1:0] entry_count;
    } t_res;

endpackage

FILE: rtl/core/fts_ctrl.sv
// ----------------------------------------------------------------------------
// fts_ctrl
// Table memory and the sequencer that scans, updates and compacts it.
// ----------------------------------------------------------------------------
module fts_ctrl #(
    parameter int FRAME_SLOTS = fts_pkg::FRAME_SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [fts_pkg::PAGE_W-1:0] i_kernel_base,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  logic [2:0]                i_op,
    input  logic [fts_pkg::PAGE_W-1:0] i_page,
    input  logic                      i_pin_value,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output fts_pkg::t_res             o_res
);
    import fts_pkg::*;

    localparam int AW = $clog2(FRAME_SLOTS);
    localparam int CW = $clog2(FRAME_SLOTS + 1);
    localparam int DW = PAGE_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_FD_RD, S_FD_CK, S_EV_RD, S_EV_CK, S_SH_RD, S_SH_WR, S_APPEND, S_DONE
    } t_state;

    t_state            r_state;
    logic [2:0]        r_op;
    logic [PAGE_W-1:0] r_page;
    logic              r_pin;
    logic [CW-1:0]     r_occ;
    logic [CW-1:0]     r_idx;
    logic [2:0]        r_status;
    logic              r_vvalid;
    logic [PAGE_W-1:0] r_vpage;
    logic              r_first_vld;
    logic [CW-1:0]     r_first_idx;
    logic [PAGE_W-1:0] r_first_page;

    // Entry word: page, pinned mark, accessed mark.
    logic [DW-1:0] mem [FRAME_SLOTS];
    logic [DW-1:0] rd_q;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    logic [DW-1:0] wd;

    logic [PAGE_W-1:0] q_page;
    logic              q_pin;
    logic              q_acc;
    logic              last;
    logic [CW-1:0]     idx_inc;

    assign q_page  = rd_q[DW-1:2];
    assign q_pin   = rd_q[1];
    assign q_acc   = rd_q[0];
    assign idx_inc = r_idx + CW'(1);
    assign last    = (idx_inc == r_occ);

    always_comb begin
        rd_addr = r_idx[AW-1:0];
        if (r_state == S_SH_RD) begin
            rd_addr = idx_inc[AW-1:0];
        end
    end

    always_comb begin
        we = 1'b0;
        wa = r_idx[AW-1:0];
        wd = rd_q;
        case (r_state)
            S_FD_CK: begin
                if (q_page == r_page && r_op == OP_TOUCH) begin
                    we = 1'b1;
                    wd = {q_page, q_pin, 1'b1};
                end else if (q_page == r_page && r_op == OP_PIN) begin
                    we = 1'b1;
                    wd = {q_page, r_pin, q_acc};
                end
            end
            S_EV_CK: begin
                if (!q_pin && q_acc) begin
                    we = 1'b1;
                    wd = {q_page, q_pin, 1'b0};
                end
            end
            S_SH_WR: we = 1'b1;
            S_APPEND: begin
                we = 1'b1;
                wa = r_occ[AW-1:0];
                wd = {r_page, r_pin, 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        rd_q <= mem[rd_addr];
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_op        <= i_op;
                        r_page      <= i_page;
                        r_pin       <= i_pin_value;
                        r_idx       <= '0;
                        r_vvalid    <= 1'b0;
                        r_vpage     <= '0;
                        r_status    <= ST_OK;
                        r_first_vld <= 1'b0;
                        if (i_op <= OP_PIN && i_page >= i_kernel_base) begin
                            r_status <= ST_KERNEL;
                            r_state  <= S_DONE;
                        end else if (i_op <= OP_PIN) begin
                            if (r_occ != '0) begin
                                r_state <= S_FD_RD;
                            end else if (i_op == OP_INSERT) begin
                                r_state <= S_APPEND;
                            end else begin
                                r_status <= ST_NOT_FOUND;
                                r_state  <= S_DONE;
                            end
                        end else if (i_op == OP_EVICT) begin
                            if (r_occ != '0) begin
                                r_state <= S_EV_RD;
                            end else begin
                                r_status <= ST_NO_VICTIM;
                                r_state  <= S_DONE;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_FD_RD: r_state <= S_FD_CK;
                S_FD_CK: begin
                    if (q_page == r_page) begin
                        if (r_op == OP_INSERT) begin
                            r_status <= ST_DUPLICATE;
                            r_state  <= S_DONE;
                        end else if (r_op == OP_REMOVE) begin
                            r_state <= S_SH_RD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (last) begin
                        if (r_op != OP_INSERT) begin
                            r_status <= ST_NOT_FOUND;
                            r_state  <= S_DONE;
                        end else if (r_occ < CW'(FRAME_SLOTS)) begin
                            r_state <= S_APPEND;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_EV_RD;
                        end
                    end else begin
                        r_idx   <= idx_inc;
                        r_state <= S_FD_RD;
                    end
                end
                S_EV_RD: r_state <= S_EV_CK;
                S_EV_CK: begin
                    if (!q_pin && !q_acc) begin
                        r_vvalid <= 1'b1;
                        r_vpage  <= q_page;
                        r_state  <= S_SH_RD;
                    end else begin
                        if (!q_pin && !r_first_vld) begin
                            r_first_vld  <= 1'b1;
                            r_first_idx  <= r_idx;
                            r_first_page <= q_page;
                        end
                        if (last) begin
                            // Every unpinned entry had its mark set and has now
                            // been cleared, so the first of them goes.
                            if (!q_pin && !r_first_vld) begin
                                r_vvalid <= 1'b1;
                                r_vpage  <= q_page;
                                r_state  <= S_SH_RD;
                            end else if (r_first_vld) begin
                                r_vvalid <= 1'b1;
                                r_vpage  <= r_first_page;
                                r_idx    <= r_first_idx;
                                r_state  <= S_SH_RD;
                            end else begin
                                r_status <= ST_NO_VICTIM;
                                r_state  <= S_DONE;
                            end
                        end else begin
                            r_idx   <= idx_inc;
                            r_state <= S_EV_RD;
                        end
                    end
                end
                S_SH_RD: begin
                    if (idx_inc < r_occ) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_occ   <= r_occ - CW'(1);
                        r_state <= (r_op == OP_INSERT) ? S_APPEND : S_DONE;
                    end
                end
                S_SH_WR: begin
                    r_idx   <= idx_inc;
                    r_state <= S_SH_RD;
                end
                S_APPEND: begin
                    r_occ   <= r_occ + CW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_ready             = (r_state == S_IDLE);
    assign o_res_valid             = (r_state == S_DONE);
    assign o_res.status            = r_status;
    assign o_res.victim_valid      = r_vvalid;
    assign o_res.victim_page       = r_vpage;
    assign o_res.entry_count       = COUNT_W'(r_occ);

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(FRAME_SLOTS))
        else $error("occupancy above table size");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !we)
        else $error("table write outside an operation");
    a_victim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && r_vvalid |-> r_status == ST_OK)
        else $error("victim reported with error status");
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_APPEND |-> r_occ < CW'(FRAME_SLOTS))
        else $error("append into a full table");

endmodule

FILE: rtl/core/frame_table_second_chance.sv
// ----------------------------------------------------------------------------
// frame_table_second_chance
// Ordered page frame table with second-chance victim selection.
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  request   i_in_valid / o_in_ready, i_op, i_page, i_pin_value   in
//  result    o_out_valid / i_out_ready, o_status, o_victim_valid,
//            o_victim_page, o_entry_count                     out
//  config    i_cfg_we, i_cfg_wdata (kernel base page)         in
//
//  Rejected or unknown requests go straight to the result; other requests
//  scan the table in order, reading one entry of the table memory at a time,
//  and a delete moves each later entry up one place. An insert into a full
//  table does a lookup, an eviction scan, a compaction and an append in turn.
//  Reset is synchronous and active low; it empties the table at once, no
//  clearing pass is needed. A new request is taken while the last result still
//  waits in the output register; a stalled result holds the sequencer in its
//  final step.
// ----------------------------------------------------------------------------
module frame_table_second_chance #(
    parameter int FRAME_SLOTS = fts_pkg::FRAME_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fts_pkg::PAGE_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_op,
    input  logic [fts_pkg::PAGE_W-1:0]  i_page,
    input  logic                        i_pin_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_status,
    output logic                        o_victim_valid,
    output logic [fts_pkg::PAGE_W-1:0]  o_victim_page,
    output logic [fts_pkg::COUNT_W-1:0] o_entry_count
);
    import fts_pkg::*;

    logic [PAGE_W-1:0] r_kernel_base;
    logic              r_out_valid;
    t_res              r_out;
    logic              res_valid;
    logic              res_ready;
    t_res              res;

    // Kernel base register; the user must write it only while the block is idle, the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_base <= KERNEL_BASE_RST;
        end else if (i_cfg_we) begin
            r_kernel_base <= i_cfg_wdata;
        end
    end

    fts_ctrl #(
        .FRAME_SLOTS(FRAME_SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kernel_base(r_kernel_base),
        .i_req_valid  (i_in_valid),
        .o_req_ready  (o_in_ready),
        .i_op         (i_op),
        .i_page       (i_page),
        .i_pin_value  (i_pin_value),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // The output register frees the sequencer as soon as a result is handed on.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_victim_valid = r_out.victim_valid;
    assign o_victim_page  = r_out.victim_page;
    assign o_entry_count  = r_out.entry_count;

endmodule
